// ===== hdl/slist_pkg.sv =====
package slist_pkg;

	// request operation codes
	localparam logic [2:0] FUNC_FRONT   = 3'd0;
	localparam logic [2:0] FUNC_ORDERED = 3'd1;
	localparam logic [2:0] FUNC_DELETE  = 3'd2;
	localparam logic [2:0] FUNC_SEARCH  = 3'd3;
	localparam logic [2:0] FUNC_CLEAR   = 3'd4;

	localparam int unsigned VALUE_W = 32;
	localparam int unsigned OCC_W   = 5;

	// token that walks the cell chain, one cell per cycle
	typedef struct packed {
		logic               active;
		logic [2:0]         op;
		logic [VALUE_W-1:0] value;  // request value, or the carried entry while shifting
		logic               shift;  // insert: carrying; delete/search: match found
		logic               done;   // insert: value has landed in a free cell
	} slist_tok_t;

endpackage

// ===== hdl/slist_cell.sv =====
module slist_cell
	import slist_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               clr,
	input  logic               descending_order,
	input  slist_tok_t         tok_i,
	input  logic [VALUE_W-1:0] next_entry,
	input  logic               next_occ,
	output slist_tok_t         tok_o,
	output logic [VALUE_W-1:0] entry,
	output logic               occ
);

	logic [VALUE_W-1:0] entry_q;
	logic               occ_q;
	slist_tok_t         tok_q;

	logic [VALUE_W-1:0] nxt_entry;
	logic               nxt_occ;
	slist_tok_t         nxt_tok;
	logic               before_here;
	logic               equal;

	assign equal = occ_q && (entry_q == tok_i.value);

	// ordered insert goes in front of the first entry at or past the value
	always_comb begin
		if (descending_order) begin
			before_here = $signed(entry_q) <= $signed(tok_i.value);
		end else begin
			before_here = $signed(entry_q) >= $signed(tok_i.value);
		end
	end

	always_comb begin
		nxt_entry = entry_q;
		nxt_occ   = occ_q;
		nxt_tok   = tok_i;
		if (tok_i.active) begin
			case (tok_i.op) inside
				FUNC_FRONT, FUNC_ORDERED: begin
					if (!tok_i.done) begin
						if (!occ_q) begin
							nxt_entry    = tok_i.value;
							nxt_occ      = 1'b1;
							nxt_tok.done = 1'b1;
						end else if (tok_i.shift || tok_i.op == FUNC_FRONT || before_here) begin
							// take the carried value, hand the old entry on
							nxt_entry     = tok_i.value;
							nxt_tok.value = entry_q;
							nxt_tok.shift = 1'b1;
						end
					end
				end
				FUNC_DELETE: begin
					if (tok_i.shift || equal) begin
						// close the gap: pull the right neighbor in
						nxt_entry     = next_entry;
						nxt_occ       = next_occ;
						nxt_tok.shift = 1'b1;
					end
				end
				FUNC_SEARCH: begin
					if (equal) begin
						nxt_tok.shift = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
			tok_q <= '0;
		end else begin
			occ_q <= clr ? 1'b0 : nxt_occ;
			tok_q <= nxt_tok;
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= nxt_entry;
	end

	assign tok_o = tok_q;
	assign entry = entry_q;
	assign occ   = occ_q;

endmodule

// ===== hdl/sorted_list_engine_top.sv =====
// sorted list engine: a bounded list of signed 32-bit values kept in a chain of cells
//
// request channel: in_valid / in_stall with func and value; a request is taken at
// a rising edge with in_valid high and in_stall low. result channel: out_valid /
// out_stall with hit, rejected and occupancy, one result per request, in order.
// cfg_we / cfg_wdata write the descending_order bit; write it only while idle.
//
// insert front, ordered insert, delete and search send a token down the chain,
// one cell per cycle; the result is registered when the token leaves the last
// cell; no new request is taken while it is in the chain. clear, an insert into
// a full list and unused codes skip the chain, are registered as they are taken,
// and can follow each other every cycle while the result is not stalled.
//
// reset empties the list and clears descending_order; entry values are not reset.
// while the result register is full and stalled, no new request is taken, so a
// stalled result simply holds until the receiver takes it.
module sorted_list_engine_top
	import slist_pkg::*;
#(
	parameter int unsigned CAPACITY = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic                      cfg_wdata,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [2:0]                func,
	input  logic signed [VALUE_W-1:0] value,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      hit,
	output logic                      rejected,
	output logic [OCC_W-1:0]          occupancy
);

	localparam int unsigned CW = $clog2(CAPACITY + 1);

	// control registers
	logic          descending_q;
	logic          busy_q;
	logic [CW-1:0] count_q;
	logic          out_valid_q;
	logic          hit_q;
	logic          rejected_q;
	logic [CW-1:0] occ_count_q;

	// cell chain wiring; tok[i] enters cell i, tok[CAPACITY] leaves the last cell
	slist_tok_t         tok [CAPACITY+1];
	logic [VALUE_W-1:0] entry_w [CAPACITY+1];
	logic               occ_w [CAPACITY+1];

	logic          launch;
	logic          is_insert;
	logic          walks_chain;
	logic          full;
	logic          immediate;
	logic          clr;
	slist_tok_t    tok_start;
	slist_tok_t    tok_end;
	logic [CW+OCC_W-1:0] occ_ext;

	// one request at a time; the result register is free whenever a request is taken
	assign in_stall = busy_q || (out_valid_q && out_stall);
	assign launch   = in_valid && !in_stall;

	assign full      = (count_q == CW'(CAPACITY));
	assign is_insert = (func == FUNC_FRONT) || (func == FUNC_ORDERED);
	assign walks_chain = is_insert || (func == FUNC_DELETE) || (func == FUNC_SEARCH);
	// clear, unused codes and an insert into a full list never send a token down the chain
	assign immediate = !walks_chain || (is_insert && full);
	assign clr       = launch && (func == FUNC_CLEAR);

	always_comb begin
		tok_start        = '0;
		tok_start.active = launch && !immediate;
		tok_start.op     = func;
		tok_start.value  = value;
	end

	assign tok[0] = tok_start;

	// past the last cell there is nothing to pull in on delete
	assign entry_w[CAPACITY] = '0;
	assign occ_w[CAPACITY]   = 1'b0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		slist_cell u_cell (
			.clk              (clk),
			.arst_n           (arst_n),
			.clr              (clr),
			.descending_order (descending_q),
			.tok_i            (tok[i]),
			.next_entry       (entry_w[i+1]),
			.next_occ         (occ_w[i+1]),
			.tok_o            (tok[i+1]),
			.entry            (entry_w[i]),
			.occ              (occ_w[i])
		);
	end

	assign tok_end = tok[CAPACITY];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			descending_q <= 1'b0;
		end else if (cfg_we) begin
			descending_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (launch) begin
				if (immediate) begin
					out_valid_q <= 1'b1;
					if (clr) begin
						count_q <= '0;
					end
				end else begin
					busy_q <= 1'b1;
					// an accepted insert always lands, so count it now
					if (is_insert) begin
						count_q <= count_q + CW'(1);
					end
				end
			end
			if (tok_end.active) begin
				busy_q      <= 1'b0;
				out_valid_q <= 1'b1;
				if (tok_end.op == FUNC_DELETE && tok_end.shift) begin
					count_q <= count_q - CW'(1);
				end
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (launch && immediate) begin
			hit_q       <= 1'b0;
			rejected_q  <= is_insert && full;
			occ_count_q <= clr ? '0 : count_q;
		end
		if (tok_end.active) begin
			hit_q      <= tok_end.shift &&
			              (tok_end.op == FUNC_DELETE || tok_end.op == FUNC_SEARCH);
			rejected_q <= 1'b0;
			if (tok_end.op == FUNC_DELETE && tok_end.shift) begin
				occ_count_q <= count_q - CW'(1);
			end else begin
				occ_count_q <= count_q;
			end
		end
	end

	// occupancy reports the low bits of the count
	assign occ_ext   = {{OCC_W{1'b0}}, occ_count_q};
	assign occupancy = occ_ext[OCC_W-1:0];
	assign out_valid = out_valid_q;
	assign hit       = hit_q;
	assign rejected  = rejected_q;

endmodule
